// ===== rtl/core/rlim_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlim_pkg
// Shared constants and types for the per-client fixed-window rate limiter.
// ----------------------------------------------------------------------------
package rlim_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 20;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // field widths
    localparam int ADDR_W  = 32;
    localparam int MS_W    = 32;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam logic [MS_W-1:0]    WINDOW_MS_RST    = 32'd60000;
    localparam logic [COUNT_W-1:0] MAX_REQUESTS_RST = 16'd60;
    localparam logic [COUNT_W-1:0] COUNT_SAT        = {COUNT_W{1'b1}};

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT_ENABLE = 2'd0,
        REG_WINDOW_MS    = 2'd1,
        REG_MAX_REQUESTS = 2'd2
    } cfg_reg_t;

    // one table entry as stored in the RAM
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [MS_W-1:0]    win_start;
        logic [COUNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage : rlim_pkg
`default_nettype wire

// ===== rtl/core/rlim_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlim_req_if / rlim_resp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface rlim_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] client_ip;
    logic [31:0] now_ms;

    modport source (output valid, output client_ip, output now_ms, input ready);
    modport sink   (input valid, input client_ip, input now_ms, output ready);
endinterface : rlim_req_if

interface rlim_resp_if;
    logic valid;
    logic ready;
    logic allowed;
    logic first_over_limit;

    modport source (output valid, output allowed, output first_over_limit, input ready);
    modport sink   (input valid, input allowed, input first_over_limit, output ready);
endinterface : rlim_resp_if
`default_nettype wire

// ===== rtl/core/rlim_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlim_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rlim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : rlim_ram
`default_nettype wire

// ===== rtl/core/per_client_fixed_window_rate_limiter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_client_fixed_window_rate_limiter
// Looks up the client in a table of address, window start and count, and
// allows or denies the request word against a fixed window limit.
// ----------------------------------------------------------------------------
//  channel | dir | payload                       | accepted when
//  req     | in  | client_ip[32], now_ms[32]     | req.valid & req.ready
//  resp    | out | allowed, first_over_limit     | resp.valid & resp.ready
//  cfg     | in  | cfg_index[2], cfg_data[32]    | cfg_wr_en
//
//  Scan: each request walks the table RAM, one entry read per cycle, until the
//  client is found or the last entry is checked; disabled requests skip it.
//  Reset: control and config registers take reset values; per-entry valid
//  bits clear the table at once, an entry not yet written reads as all zero.
//  Stalls: req.ready is high only between requests; a result waiting in the
//  output register holds the write-back of the next request until taken.
// ----------------------------------------------------------------------------
module per_client_fixed_window_rate_limiter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    rlim_req_if.sink                        req,
    rlim_resp_if.source                     resp,
    input  wire logic                       cfg_wr_en,
    input  wire logic [rlim_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rlim_pkg::CFG_W-1:0] cfg_data
);
    import rlim_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // configuration registers
    logic                 limit_enable_reg;
    logic [MS_W-1:0]      window_ms_reg;
    logic [COUNT_W-1:0]   max_requests_reg;

    // control
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     issue_reg, issue_next;
    logic                 issue_done_reg, issue_done_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     chk_reg, chk_next;
    logic                 found_reg, found_next;
    logic                 dis_reg, dis_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 allowed_reg, allowed_next;
    logic                 first_reg, first_next;

    // item payload
    logic [ADDR_W-1:0]    ip_reg, ip_next;
    logic [MS_W-1:0]      now_reg, now_next;
    logic [MS_W-1:0]      least_reg, least_next;
    logic [IDX_W-1:0]     victim_reg, victim_next;
    logic [IDX_W-1:0]     hit_reg, hit_next;
    logic [MS_W-1:0]      hit_time_reg, hit_time_next;
    logic [COUNT_W-1:0]   hit_count_reg, hit_count_next;

    // RAM port signals
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    logic                 ram_re;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               rd_entry;

    // update path
    logic [MS_W-1:0]      elapsed;
    logic                 expired;
    logic [COUNT_W-1:0]   after;
    logic                 deny;
    logic                 first_hit;
    logic                 fire;

    rlim_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_reg),
        .rdata (ram_rdata)
    );

    assign req.ready        = (state_reg == ST_IDLE);
    assign resp.valid       = out_valid_reg;
    assign resp.allowed     = allowed_reg;
    assign resp.first_over_limit = first_reg;

    // mask entries never written to the cleared value
    assign rd_entry = valid_reg[chk_reg] ? entry_t'(ram_rdata) : '0;
    assign ram_re   = (state_reg == ST_SCAN) && !issue_done_reg;

    // decide the update for a found or missing client
    assign elapsed   = now_reg - hit_time_reg;
    assign expired   = elapsed > window_ms_reg;
    assign after     = (hit_count_reg == COUNT_SAT) ? hit_count_reg : hit_count_reg + 1'b1;
    assign deny      = found_reg && !expired && (after > max_requests_reg);
    assign first_hit = deny && (hit_count_reg != COUNT_SAT)
                       && ({1'b0, after} == ({1'b0, max_requests_reg} + 17'd1));
    assign fire      = (state_reg == ST_UPDATE) && (!out_valid_reg || resp.ready);

    always_comb
    begin
        ram_we    = fire && !dis_reg;
        ram_waddr = found_reg ? hit_reg : victim_reg;
        ram_wdata.addr      = ip_reg;
        ram_wdata.win_start = now_reg;
        ram_wdata.count     = 16'd1;
        if (found_reg && !expired)
        begin
            ram_wdata.win_start = hit_time_reg;
            ram_wdata.count     = after;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        issue_done_next = issue_done_reg;
        pend_next       = ram_re;
        chk_next        = issue_reg;
        found_next      = found_reg;
        dis_next        = dis_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        allowed_next    = allowed_reg;
        first_next      = first_reg;
        ip_next         = ip_reg;
        now_next        = now_reg;
        least_next      = least_reg;
        victim_next     = victim_reg;
        hit_next        = hit_reg;
        hit_time_next   = hit_time_reg;
        hit_count_next  = hit_count_reg;

        // drop the result once taken
        if (out_valid_reg && resp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    ip_next         = req.client_ip;
                    now_next        = req.now_ms;
                    least_next      = req.now_ms;
                    victim_next     = '0;
                    found_next      = 1'b0;
                    dis_next        = !limit_enable_reg;
                    issue_next      = '0;
                    issue_done_next = 1'b0;
                    state_next      = limit_enable_reg ? ST_SCAN : ST_UPDATE;
                end
            end
            ST_SCAN:
            begin
                // advance the read pointer
                if (ram_re)
                begin
                    if (issue_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        issue_next = issue_reg + 1'b1;
                    end
                end
                // check the entry read last cycle
                if (pend_reg)
                begin
                    if (rd_entry.addr == ip_reg)
                    begin
                        found_next     = 1'b1;
                        hit_next       = chk_reg;
                        hit_time_next  = rd_entry.win_start;
                        hit_count_next = rd_entry.count;
                        state_next     = ST_UPDATE;
                    end
                    else
                    begin
                        if (rd_entry.win_start < least_reg)
                        begin
                            least_next  = rd_entry.win_start;
                            victim_next = chk_reg;
                        end
                        if (chk_reg == LAST_IDX)
                        begin
                            state_next = ST_UPDATE;
                        end
                    end
                end
            end
            ST_UPDATE:
            begin
                // write back and present the result
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    allowed_next   = dis_reg || !deny;
                    first_next     = !dis_reg && first_hit;
                    if (!dis_reg)
                    begin
                        valid_next[ram_waddr] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold state, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_reg        <= '0;
            issue_done_reg   <= 1'b0;
            pend_reg         <= 1'b0;
            chk_reg          <= '0;
            found_reg        <= 1'b0;
            dis_reg          <= 1'b0;
            valid_reg        <= '0;
            out_valid_reg    <= 1'b0;
            allowed_reg      <= 1'b0;
            first_reg        <= 1'b0;
            limit_enable_reg <= 1'b1;
            window_ms_reg    <= WINDOW_MS_RST;
            max_requests_reg <= MAX_REQUESTS_RST;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            chk_reg        <= chk_next;
            found_reg      <= found_next;
            dis_reg        <= dis_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            allowed_reg    <= allowed_next;
            first_reg      <= first_next;
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_LIMIT_ENABLE: limit_enable_reg <= cfg_data[0];
                    REG_WINDOW_MS:    window_ms_reg    <= cfg_data;
                    REG_MAX_REQUESTS: max_requests_reg <= cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // item payload, no reset
    always_ff @(posedge clk)
    begin
        ip_reg        <= ip_next;
        now_reg       <= now_next;
        least_reg     <= least_next;
        victim_reg    <= victim_next;
        hit_reg       <= hit_next;
        hit_time_reg  <= hit_time_next;
        hit_count_reg <= hit_count_next;
    end

    // checks
    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_UPDATE))
        else $error("table written outside update");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("update did not present a result");

    a_check_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (chk_reg <= LAST_IDX))
        else $error("scan index out of range");

    a_deny_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !allowed_next) |-> (found_reg && !dis_reg))
        else $error("denial without a matching entry");

endmodule : per_client_fixed_window_rate_limiter
`default_nettype wire
